/* rtl/core/ffga_pkg.sv */
// Shared types and constants for the first-fit granule allocator.
// No dependencies.
package ffga_pkg;

    localparam int GRANULES_DEF   = 4096;
    localparam int MAX_GRANTS_DEF = 64;
    localparam int GRANULE_SHIFT  = 5;

    localparam logic [1:0] MODE_ANY     = 2'd0;
    localparam logic [1:0] MODE_AT      = 2'd1;
    localparam logic [1:0] MODE_RELEASE = 2'd2;
    localparam logic [1:0] MODE_UNUSED  = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_ZERO      = 3'd1;
    localparam logic [2:0] ST_NO_SPACE  = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_IGNORED   = 3'd4;

    localparam logic CFG_BASE  = 1'b0;
    localparam logic CFG_BYTES = 1'b1;

    typedef enum logic [1:0] {
        OP_ANY,
        OP_AT,
        OP_RELEASE,
        OP_REJECT
    } op_t;

    // classified item handed from front to back
    typedef struct packed {
        op_t         op;
        logic [2:0]  status;
        logic [12:0] need;
        logic [31:0] rel;
        logic [12:0] avail;
    } cmd_t;

endpackage

/* rtl/core/ffga_front.sv */
// Front end: accepts items, rounds sizes, classifies and queues commands.
// Depends on ffga_pkg.
module ffga_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 valid_in,
    output logic                 stall_in,
    input  logic [1:0]           mode,
    input  logic [17:0]          request_size,
    input  logic [31:0]          address,
    input  logic [31:0]          base_reg,
    input  logic [17:0]          bytes_reg,
    input  logic [12:0]          avail,
    output logic                 cmd_valid,
    input  logic                 cmd_take,
    output ffga_pkg::cmd_t       cmd
);

    ffga_pkg::cmd_t q_reg [2];
    logic [1:0]     cnt_reg;
    logic           rd_reg;
    logic           wr_reg;
    ffga_pkg::cmd_t c;
    logic [31:0]    rel;
    logic [18:0]    need19;
    logic           push;
    logic           pop;

    always_comb
    begin
        rel    = address - base_reg;
        need19 = ({1'b0, request_size} + 19'd31) >> ffga_pkg::GRANULE_SHIFT;
        c.rel    = rel;
        c.avail  = avail;
        c.need   = need19[12:0];
        c.status = ffga_pkg::ST_OK;
        c.op     = ffga_pkg::OP_REJECT;
        case (mode)
            ffga_pkg::MODE_ANY, ffga_pkg::MODE_AT:
            begin
                if (request_size == 18'd0)
                    c.status = ffga_pkg::ST_ZERO;
                else if (need19 > {6'd0, avail})
                    c.status = ffga_pkg::ST_NO_SPACE;
                else if (mode == ffga_pkg::MODE_ANY)
                    c.op = ffga_pkg::OP_ANY;
                else if (address < base_reg || rel[4:0] != 5'd0)
                    c.status = ffga_pkg::ST_NO_SPACE;
                else
                    c.op = ffga_pkg::OP_AT;
            end
            ffga_pkg::MODE_RELEASE:
            begin
                if (address < base_reg || rel[4:0] != 5'd0 || rel >= {14'd0, bytes_reg})
                    c.status = ffga_pkg::ST_IGNORED;
                else
                    c.op = ffga_pkg::OP_RELEASE;
            end
            default:
                c.status = ffga_pkg::ST_IGNORED;
        endcase
    end

    assign stall_in  = (cnt_reg == 2'd2);
    assign push      = valid_in && !stall_in;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign pop       = cmd_valid && cmd_take;
    assign cmd       = q_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_reg] <= c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end
        else
        begin
            if (push)
                wr_reg <= !wr_reg;
            if (pop)
                rd_reg <= !rd_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= 2'd2)
        else $error("queue overfull");
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd2 |-> !push) else $error("push into full queue");
    a_pop_only_valid: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> cnt_reg != 2'd0) else $error("pop from empty queue");

endmodule

/* rtl/core/ffga_back.sv */
// Back end: scans the free map and grant table, commits changes, emits results.
// Depends on ffga_pkg.
module ffga_back #(
    parameter int GRANULES   = ffga_pkg::GRANULES_DEF,
    parameter int MAX_GRANTS = ffga_pkg::MAX_GRANTS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_take,
    input  ffga_pkg::cmd_t       cmd,
    input  logic [31:0]          base_reg,
    output logic                 valid_out,
    input  logic                 stall_out,
    output logic [2:0]           status,
    output logic [31:0]          result_address,
    output logic [27:0]          stamp
);

    localparam int GW = $clog2(GRANULES);
    localparam int GC = GW + 1;
    localparam int TW = (MAX_GRANTS > 1) ? $clog2(MAX_GRANTS) : 1;
    localparam int TC = $clog2(MAX_GRANTS + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_CLR, S_SCAN, S_SLOT, S_SLOTRD, S_MARK, S_FIND, S_FINDRD,
        S_FREE, S_OUT
    } state_t;

    state_t             state_reg;
    logic [GW-1:0]      clr_reg;
    logic               map_mem [GRANULES];
    logic [GW-1:0]      tbl_mem [MAX_GRANTS];
    logic [MAX_GRANTS-1:0] tv_reg;
    ffga_pkg::cmd_t     c_reg;
    logic [GC-1:0]      idx_reg;
    logic [GC-1:0]      run_reg;
    logic [GC-1:0]      first_reg;
    logic [GC-1:0]      left_reg;
    logic [TC-1:0]      slot_reg;
    logic               map_rd_reg;
    logic [GW-1:0]      tbl_rd_reg;
    logic               map_we;
    logic [GW-1:0]      map_wa;
    logic               map_wd;
    logic [GW-1:0]      map_ra;
    logic [GC-1:0]      need_g;
    logic [GC-1:0]      avail_g;
    logic [GC-1:0]      relg;
    logic               rd_pend_reg;

    assign need_g   = GC'(c_reg.need);
    assign avail_g  = GC'(c_reg.avail);
    assign relg     = GC'(c_reg.rel >> ffga_pkg::GRANULE_SHIFT);
    assign cmd_take = (state_reg == S_IDLE);
    assign valid_out = (state_reg == S_OUT);
    assign map_ra   = idx_reg[GW-1:0];

    always_ff @(posedge clk)
    begin
        if (map_we)
            map_mem[map_wa] <= map_wd;
        map_rd_reg <= map_mem[map_ra];
        tbl_rd_reg <= tbl_mem[slot_reg[TW-1:0]];
        if (state_reg == S_MARK && left_reg == need_g && c_reg.op != ffga_pkg::OP_RELEASE)
            tbl_mem[slot_reg[TW-1:0]] <= first_reg[GW-1:0];
    end

    always_comb
    begin
        map_we = 1'b0;
        map_wa = idx_reg[GW-1:0];
        map_wd = 1'b1;
        if (state_reg == S_CLR)
        begin
            map_we = 1'b1;
            map_wa = clr_reg;
        end
        else if (state_reg == S_MARK || state_reg == S_FREE)
        begin
            map_we = (left_reg != '0) && (idx_reg < GC'(GRANULES));
            map_wd = (state_reg == S_FREE);
        end
    end

    logic [GC-1:0] len_mem [MAX_GRANTS];

    always_ff @(posedge clk)
    begin
        if (state_reg == S_MARK && left_reg == need_g && c_reg.op != ffga_pkg::OP_RELEASE)
            len_mem[slot_reg[TW-1:0]] <= need_g;
    end

    logic [GC-1:0] len_rd_reg;
    always_ff @(posedge clk)
    begin
        len_rd_reg <= len_mem[slot_reg[TW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLR;
            clr_reg        <= '0;
            tv_reg         <= '0;
            rd_pend_reg    <= 1'b0;
            c_reg          <= '0;
            status         <= '0;
            result_address <= '0;
            stamp          <= '0;
            idx_reg        <= '0;
            run_reg        <= '0;
            first_reg      <= '0;
            left_reg       <= '0;
            slot_reg       <= '0;
        end
        else
        begin
            case (state_reg)
                S_CLR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == GW'(GRANULES - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        c_reg       <= cmd;
                        status      <= cmd.status;
                        result_address <= '0;
                        stamp       <= '0;
                        idx_reg     <= '0;
                        run_reg     <= '0;
                        slot_reg    <= '0;
                        rd_pend_reg <= 1'b0;
                        case (cmd.op)
                            ffga_pkg::OP_ANY:     state_reg <= S_SCAN;
                            ffga_pkg::OP_AT:
                            begin
                                idx_reg <= GC'(cmd.rel >> ffga_pkg::GRANULE_SHIFT);
                                state_reg <= S_SCAN;
                            end
                            ffga_pkg::OP_RELEASE: state_reg <= S_FIND;
                            default:              state_reg <= S_OUT;
                        endcase
                    end
                end
                S_SCAN:
                begin
                    if (c_reg.op == ffga_pkg::OP_AT && (c_reg.rel[31:ffga_pkg::GRANULE_SHIFT]
                        >= 27'(avail_g) || need_g > avail_g - relg))
                    begin
                        status    <= ffga_pkg::ST_NO_SPACE;
                        state_reg <= S_OUT;
                    end
                    else if (!rd_pend_reg)
                        rd_pend_reg <= 1'b1;
                    else
                    begin
                        rd_pend_reg <= 1'b0;
                        if (map_rd_reg)
                        begin
                            if (run_reg + 1'b1 == need_g)
                            begin
                                first_reg <= idx_reg + 1'b1 - need_g;
                                state_reg <= S_SLOT;
                            end
                            run_reg <= run_reg + 1'b1;
                            idx_reg <= idx_reg + 1'b1;
                        end
                        else if (c_reg.op == ffga_pkg::OP_AT || idx_reg + 1'b1 >= avail_g)
                        begin
                            status    <= ffga_pkg::ST_NO_SPACE;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            run_reg <= '0;
                            idx_reg <= idx_reg + 1'b1;
                        end
                        if (map_rd_reg && run_reg + 1'b1 != need_g
                            && c_reg.op == ffga_pkg::OP_ANY && idx_reg + 1'b1 >= avail_g)
                        begin
                            status    <= ffga_pkg::ST_NO_SPACE;
                            state_reg <= S_OUT;
                        end
                    end
                end
                S_SLOT:
                begin
                    if (slot_reg == TC'(MAX_GRANTS))
                    begin
                        status    <= ffga_pkg::ST_FULL;
                        state_reg <= S_OUT;
                    end
                    else if (!tv_reg[slot_reg[TW-1:0]])
                    begin
                        tv_reg[slot_reg[TW-1:0]] <= 1'b1;
                        idx_reg   <= first_reg;
                        left_reg  <= need_g;
                        state_reg <= S_MARK;
                    end
                    else
                        slot_reg <= slot_reg + 1'b1;
                end
                S_MARK:
                begin
                    if (left_reg == '0)
                    begin
                        status         <= ffga_pkg::ST_OK;
                        result_address <= base_reg
                                          + (32'(first_reg) << ffga_pkg::GRANULE_SHIFT);
                        stamp          <= (28'(first_reg) << 16) | 28'(need_g);
                        state_reg      <= S_OUT;
                    end
                    else
                    begin
                        idx_reg  <= idx_reg + 1'b1;
                        left_reg <= left_reg - 1'b1;
                    end
                end
                S_FIND:
                begin
                    if (slot_reg == TC'(MAX_GRANTS))
                    begin
                        status    <= ffga_pkg::ST_IGNORED;
                        state_reg <= S_OUT;
                    end
                    else if (!rd_pend_reg)
                        rd_pend_reg <= 1'b1;
                    else
                    begin
                        rd_pend_reg <= 1'b0;
                        if (tv_reg[slot_reg[TW-1:0]]
                            && 32'(tbl_rd_reg) == 32'(c_reg.rel
                               >> ffga_pkg::GRANULE_SHIFT))
                        begin
                            tv_reg[slot_reg[TW-1:0]] <= 1'b0;
                            idx_reg   <= relg;
                            left_reg  <= len_rd_reg;
                            state_reg <= S_FREE;
                        end
                        else
                            slot_reg <= slot_reg + 1'b1;
                    end
                end
                S_FREE:
                begin
                    if (left_reg == '0)
                    begin
                        status    <= ffga_pkg::ST_OK;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        idx_reg  <= idx_reg + 1'b1;
                        left_reg <= left_reg - 1'b1;
                    end
                end
                S_OUT:
                begin
                    if (!stall_out)
                        state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    a_ok_addr_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        valid_out && status != ffga_pkg::ST_OK |-> result_address == '0 && stamp == '0)
        else $error("failed item carries data");
    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_take |-> state_reg == S_IDLE) else $error("take while busy");
    a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
        valid_out && stall_out |=> valid_out && $stable(status))
        else $error("result dropped");

endmodule

/* rtl/core/first_fit_granule_allocator.sv */
// Top level of the first-fit granule allocator: config registers, front, back.
// A rejected item goes straight to the result; a reserve scans the free map granule
// by granule, then searches the grant table for a free slot and marks its granules;
// a release searches the grant table for the grant, then frees its granules.
// One item in the back end at a time. After reset a clearing pass over every map
// granule runs before the first item. Depends on ffga_pkg, ffga_front, ffga_back.
module first_fit_granule_allocator #(
    parameter int GRANULES   = ffga_pkg::GRANULES_DEF,
    parameter int MAX_GRANTS = ffga_pkg::MAX_GRANTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        valid_in,
    output logic        stall_in,
    input  logic [1:0]  mode,
    input  logic [17:0] request_size,
    input  logic [31:0] address,
    output logic        valid_out,
    input  logic        stall_out,
    output logic [2:0]  status,
    output logic [31:0] result_address,
    output logic [27:0] stamp
);

    logic [31:0]    base_reg;
    logic [17:0]    bytes_reg;
    logic [12:0]    avail;
    logic           cmd_valid;
    logic           cmd_take;
    ffga_pkg::cmd_t cmd;

    assign avail = (32'(bytes_reg[17:5]) > 32'(GRANULES)) ? 13'(GRANULES) : bytes_reg[17:5];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= '0;
            bytes_reg <= 18'd65536;
        end
        else if (cfg_we)
        begin
            if (cfg_index == ffga_pkg::CFG_BASE)
                base_reg <= cfg_data;
            else
                bytes_reg <= cfg_data[17:0];
        end
    end

    ffga_front u_front (
        .clk(clk), .rst_n(rst_n), .valid_in(valid_in), .stall_in(stall_in),
        .mode(mode), .request_size(request_size), .address(address),
        .base_reg(base_reg), .bytes_reg(bytes_reg), .avail(avail),
        .cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd)
    );

    ffga_back #(.GRANULES(GRANULES), .MAX_GRANTS(MAX_GRANTS)) u_back (
        .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd_take(cmd_take),
        .cmd(cmd), .base_reg(base_reg), .valid_out(valid_out),
        .stall_out(stall_out), .status(status),
        .result_address(result_address), .stamp(stamp)
    );

endmodule
